// File: rtl/gpsd_pkg.sv
// ----------------------------------------------------------------------------
// gpsd_pkg
// Shared types, constants and the button decode for the gamepad frame decoder.
// ----------------------------------------------------------------------------
package gpsd_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'h80;
    localparam int         PAYLOAD_LEN = 6;
    localparam int         POS_W       = 3;
    localparam int         SUM_W       = 7;
    localparam int         AXIS_W      = 7;
    localparam int         BTN_W       = 14;
    localparam logic [1:0] PAIR_MASK   = 2'b11;

    // one decoded record
    typedef struct packed {
        logic [BTN_W-1:0]  buttons;
        logic [AXIS_W-1:0] left_x;
        logic [AXIS_W-1:0] left_y;
        logic [AXIS_W-1:0] right_x;
        logic [AXIS_W-1:0] right_y;
    } gpsd_rec_t;

    // b0: payload byte 0 bits 0-4, b1: payload byte 1 bits 0-6
    function automatic logic [BTN_W-1:0] decode_buttons(
        input logic [4:0] b0,
        input logic [6:0] b1
    );
        logic [BTN_W-1:0] m;
        m = '0;
        m[4:0] = b0;
        // both dpad up and down set means start
        if (b1[1:0] == PAIR_MASK)
        begin
            m[12] = 1'b1;
        end
        else
        begin
            m[5] = b1[0];
            m[6] = b1[1];
        end
        // both right and left set means select
        if (b1[3:2] == PAIR_MASK)
        begin
            m[13] = 1'b1;
        end
        else
        begin
            m[7] = b1[2];
            m[8] = b1[3];
        end
        m[11:9] = b1[6:4];
        return m;
    endfunction

endpackage

// File: rtl/gamepad_serial_frame_decoder.sv
// ----------------------------------------------------------------------------
// gamepad_serial_frame_decoder
// Decodes controller serial frames into a button mask and four stick axes.
// ----------------------------------------------------------------------------
// usage
//   input channel: one received byte per transaction on rx_byte, qualified by
//   in_valid and held off by in_stall
//   a frame is header 0x80, six payload bytes, then a checksum equal to the
//   payload sum mod 128; bytes outside a frame other than the header are
//   dropped, and a header inside a frame counts as payload
//   output channel: one record per good frame on buttons and the four axes,
//   qualified by out_valid and held off by out_stall; bad frames give nothing
// timing
//   one byte per cycle sustained while the output is not stalled; a byte is
//   registered on accept, processed by the frame tracker once the output
//   register has room, and the record of a good frame is then written into
//   the output register, which drives out_valid
//   throughput is set by the single tracker step per cycle
// reset and backpressure
//   rst_n clears the input and output valids and returns the tracker to
//   header hunt; a stalled output holds its record, and the input stage then
//   waits, so in_stall goes high once a byte is held behind it
// ----------------------------------------------------------------------------
module gamepad_serial_frame_decoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [gpsd_pkg::BTN_W-1:0]  buttons,
    output logic [gpsd_pkg::AXIS_W-1:0] left_x,
    output logic [gpsd_pkg::AXIS_W-1:0] left_y,
    output logic [gpsd_pkg::AXIS_W-1:0] right_x,
    output logic [gpsd_pkg::AXIS_W-1:0] right_y
);
    import gpsd_pkg::*;

    // input register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;

    // output register
    logic       out_vld_reg, out_vld_next;
    gpsd_rec_t  out_rec_reg;

    logic       step;
    logic       rec_valid;
    gpsd_rec_t  rec;
    logic       out_free;
    logic       in_take;

    // the output register can take a new record when empty or being drained
    assign out_free = !out_vld_reg || !out_stall;

    // the held byte advances the tracker only when its result has a place
    assign step     = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    gpsd_frame_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_in   (in_byte_reg),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (out_free)
        begin
            out_vld_next = step && rec_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
        if (step && rec_valid)
        begin
            out_rec_reg <= rec;
        end
    end

    assign out_valid = out_vld_reg;
    assign buttons   = out_rec_reg.buttons;
    assign left_x    = out_rec_reg.left_x;
    assign left_y    = out_rec_reg.left_y;
    assign right_x   = out_rec_reg.right_x;
    assign right_y   = out_rec_reg.right_y;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_stall |=> out_vld_reg && $stable(out_rec_reg))
        else $error("stalled record overwritten");

    a_step_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> in_vld_reg)
        else $error("tracker stepped without a held byte");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg && out_stall)
        else $error("input stalled without a blocked output");

endmodule

// File: rtl/gpsd_frame_fsm.sv
// ----------------------------------------------------------------------------
// gpsd_frame_fsm
// Frame tracker: header hunt, payload capture, running sum and checksum test.
// ----------------------------------------------------------------------------
module gpsd_frame_fsm (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          byte_in,
    output logic                rec_valid,
    output gpsd_pkg::gpsd_rec_t rec
);
    import gpsd_pkg::*;

    typedef enum logic {
        ST_HUNT,
        ST_FRAME
    } state_t;

    state_t             state_reg, state_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [AXIS_W-1:0]  payload_reg [PAYLOAD_LEN];
    logic               store_en;
    logic               at_check;

    assign at_check = (pos_reg >= POS_W'(PAYLOAD_LEN));

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        store_en   = 1'b0;
        rec_valid  = 1'b0;
        case (state_reg)
            ST_HUNT:
            begin
                if (step && byte_in == HEADER_BYTE)
                begin
                    state_next = ST_FRAME;
                    pos_next   = '0;
                    sum_next   = '0;
                end
            end
            ST_FRAME:
            begin
                if (step)
                begin
                    if (!at_check)
                    begin
                        store_en = 1'b1;
                        pos_next = pos_reg + POS_W'(1);
                        sum_next = sum_reg + byte_in[SUM_W-1:0];
                    end
                    else
                    begin
                        // checksum with bit 7 set never matches
                        rec_valid  = (byte_in == {1'b0, sum_reg});
                        state_next = ST_HUNT;
                        pos_next   = '0;
                        sum_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
            pos_reg   <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
        end
    end

    // payload bit 7 is dropped: it is neither stored nor summed
    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            payload_reg[pos_reg] <= byte_in[AXIS_W-1:0];
        end
    end

    assign rec.buttons = decode_buttons(payload_reg[0][4:0], payload_reg[1]);
    assign rec.left_x  = payload_reg[2];
    assign rec.left_y  = payload_reg[3];
    assign rec.right_x = payload_reg[4];
    assign rec.right_y = payload_reg[5];

    a_hunt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_HUNT |-> pos_reg == '0 && sum_reg == '0)
        else $error("hunt state with stale position or sum");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(PAYLOAD_LEN))
        else $error("byte position past checksum slot");

    a_rec_only_at_check: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> step && state_reg == ST_FRAME && at_check)
        else $error("record outside checksum byte");

    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        store_en |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("position did not advance on payload byte");

endmodule
